### rtl/tss_pkg.sv
package tss_pkg;

    // Default configuration and fixed field widths.
    localparam int TSS_MAX_ROWS  = 64;
    localparam int TSS_FRAC_BITS = 20;
    localparam int DATA_W        = 32;
    localparam int ROW_W         = 6;
    localparam int PROD_W        = 64;
    localparam int WIDE_W        = 65;
    localparam int CNT_W         = 7;

    localparam logic signed [PROD_W-1:0] Q_LIMIT = 64'sh4000_0000_0000_0000;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_F_MUL,
        S_F_NUM,
        S_F_GO,
        S_F_WAIT,
        S_STORE,
        S_B_RD,
        S_B_MUL,
        S_B_NUM,
        S_B_GO,
        S_B_WAIT,
        S_B_EMIT
    } t_tss_state;

    // Multiplier operand selection.
    typedef enum logic [1:0] {
        MUL_FWD_C,
        MUL_FWD_R,
        MUL_BACK
    } t_tss_mul;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     in_take;
        logic     mul_en;
        t_tss_mul mul_sel;
        logic     num_fwd;
        logic     num_back;
        logic     div_start;
        logic     res_d;
        logic     res_r;
        logic     store;
        logic     emit;
    } t_tss_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_zero;
        logic start_back;
        logic div_done;
        logic out_busy;
        logic k_zero;
    } t_tss_sts;

    // Saturate a wide signed value to the 32-bit range.
    function automatic logic signed [DATA_W-1:0] tss_sat(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

### rtl/tss_if.sv
// Row request channel.
interface tss_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tss_pkg::DATA_W-1:0]      coef_sub;
    logic signed [tss_pkg::DATA_W-1:0]      coef_diag;
    logic signed [tss_pkg::DATA_W-1:0]      coef_super;
    logic signed [tss_pkg::DATA_W-1:0]      rhs;
    logic                                   last_row;

    modport source (output valid, coef_sub, coef_diag, coef_super, rhs, last_row,
                    input ready);
    modport sink   (input valid, coef_sub, coef_diag, coef_super, rhs, last_row,
                    output ready);
endinterface

// Solution request channel.
interface tss_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [tss_pkg::ROW_W-1:0]              row_index;
    logic signed [tss_pkg::DATA_W-1:0]      solution;
    logic                                   singular;
    logic                                   last_result;

    modport source (output valid, row_index, solution, singular, last_result,
                    input ready);
    modport sink   (input valid, row_index, solution, singular, last_result,
                    output ready);
endinterface

### rtl/tss_ram.sv
module tss_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/tss_div.sv
module tss_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tss_pkg::PROD_W-1:0]  i_dividend,
    input  logic [tss_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [tss_pkg::PROD_W-1:0]  o_quotient
);
    import tss_pkg::*;

    localparam int STEP_W = $clog2(PROD_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DATA_W:0]   r_rem, n_rem;
    logic [PROD_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic [DATA_W:0]   w_shift;
    logic              w_fit;

    // One quotient bit per cycle, restoring division on magnitudes.
    assign w_shift = {r_rem[DATA_W-1:0], r_quo[PROD_W-1]};
    assign w_fit   = w_shift >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_fit ? (w_shift - {1'b0, r_dvs}) : w_shift;
            n_quo = {r_quo[PROD_W-2:0], w_fit};
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(PROD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

### rtl/tss_ctrl.sv
module tss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tss_pkg::t_tss_sts i_sts,
    output logic              o_in_ready,
    output tss_pkg::t_tss_cmd o_cmd
);
    import tss_pkg::*;

    t_tss_state r_state, n_state;
    logic       r_phase, n_phase;

    // Next state; the phase bit picks the diagonal or right-hand-side pass.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            S_IDLE: begin
                n_phase = 1'b0;
                if (i_in_valid) begin
                    n_state = i_sts.idx_zero ? S_STORE : S_F_MUL;
                end
            end
            S_F_MUL:  n_state = S_F_NUM;
            S_F_NUM:  n_state = S_F_GO;
            S_F_GO:   n_state = S_F_WAIT;
            S_F_WAIT: begin
                if (i_sts.div_done) begin
                    n_phase = 1'b1;
                    n_state = r_phase ? S_STORE : S_F_MUL;
                end
            end
            S_STORE:  n_state = i_sts.start_back ? S_B_RD : S_IDLE;
            S_B_RD:   n_state = S_B_MUL;
            S_B_MUL:  n_state = S_B_NUM;
            S_B_NUM:  n_state = S_B_GO;
            S_B_GO:   n_state = S_B_WAIT;
            S_B_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_B_EMIT;
                end
            end
            S_B_EMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = i_sts.k_zero ? S_IDLE : S_B_RD;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_FWD_C;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.in_take = i_in_valid;
            end
            S_F_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_phase ? MUL_FWD_R : MUL_FWD_C;
            end
            S_F_NUM:  o_cmd.num_fwd = 1'b1;
            S_F_GO:   o_cmd.div_start = 1'b1;
            S_F_WAIT: begin
                o_cmd.res_d = i_sts.div_done && !r_phase;
                o_cmd.res_r = i_sts.div_done && r_phase;
            end
            S_STORE:  o_cmd.store = 1'b1;
            S_B_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_BACK;
            end
            S_B_NUM:  o_cmd.num_back = 1'b1;
            S_B_GO:   o_cmd.div_start = 1'b1;
            S_B_EMIT: o_cmd.emit = !i_sts.out_busy;
            default:  o_cmd = o_cmd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end
endmodule

### rtl/tss_dp.sv
module tss_dp #(
    parameter int MAX_ROWS  = tss_pkg::TSS_MAX_ROWS,
    parameter int FRAC_BITS = tss_pkg::TSS_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tss_pkg::t_tss_cmd i_cmd,
    output tss_pkg::t_tss_sts o_sts,
    tss_in_if.sink            i_row,
    tss_out_if.source         o_sol
);
    import tss_pkg::*;

    localparam int IW    = $clog2(MAX_ROWS);
    localparam int RAM_W = 3 * DATA_W;

    // Latched request and forward-elimination state.
    logic signed [DATA_W-1:0] r_a, r_b, r_c, r_f;
    logic                     r_last;
    logic signed [DATA_W-1:0] r_d, r_r;
    logic signed [DATA_W-1:0] r_pd, r_pr, r_pc;
    logic [IW-1:0]            r_count;
    logic [IW-1:0]            r_k;
    logic [IW-1:0]            r_top;
    logic                     r_sing;
    logic signed [DATA_W-1:0] r_vnext;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_num;
    logic signed [DATA_W-1:0] r_den;
    // Output register.
    logic                     r_o_valid;
    logic [ROW_W-1:0]         r_o_row;
    logic signed [DATA_W-1:0] r_o_sol;
    logic                     r_o_sing;
    logic                     r_o_last;

    logic [IW-1:0]            w_addr;
    logic [RAM_W-1:0]         w_rdata;
    logic signed [DATA_W-1:0] w_rd_d, w_rd_r, w_rd_c;
    logic signed [DATA_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]        w_num_mag;
    logic [DATA_W-1:0]        w_den_mag;
    logic                     w_div_done;
    logic [PROD_W-1:0]        w_quo;
    logic signed [PROD_W-1:0] w_q_s;
    logic                     w_den_zero, w_num_pos, w_num_neg;
    logic signed [PROD_W-1:0] w_q_fwd;
    logic signed [DATA_W-1:0] w_fwd_val;
    logic signed [DATA_W-1:0] w_v;
    logic signed [PROD_W-1:0] w_back_num;
    logic signed [DATA_W-1:0] w_base;

    // Row store: modified diagonal, right-hand side and super-diagonal.
    assign w_addr = i_cmd.store ? r_count : r_k;

    tss_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ROWS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (w_addr),
        .i_wdata ({r_d, r_r, r_c}),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_rd_d = w_rdata[3*DATA_W-1:2*DATA_W];
    assign w_rd_r = w_rdata[2*DATA_W-1:DATA_W];
    assign w_rd_c = w_rdata[DATA_W-1:0];

    // Shared multiplier.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_FWD_C: begin
                w_ma = r_pc;
                w_mb = r_a;
            end
            MUL_FWD_R: begin
                w_ma = r_pr;
                w_mb = r_a;
            end
            MUL_BACK: begin
                w_ma = w_rd_c;
                w_mb = r_vnext;
            end
            default: begin
                w_ma = r_pc;
                w_mb = r_a;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // Back-substitution numerator; the top row has no super-diagonal term.
    assign w_back_num = (PROD_W'(w_rd_r) <<< FRAC_BITS)
                        - ((r_k == r_top) ? PROD_W'(0) : r_prod);

    // Shared divider works on magnitudes.
    assign w_num_mag = r_num[PROD_W-1] ? PROD_W'(-r_num) : PROD_W'(r_num);
    assign w_den_mag = r_den[DATA_W-1] ? DATA_W'(-r_den) : DATA_W'(r_den);

    tss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_num_mag),
        .i_divisor  (w_den_mag),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_q_s      = (r_num[PROD_W-1] ^ r_den[DATA_W-1]) ? -$signed(w_quo) : $signed(w_quo);
    assign w_den_zero = (r_den == '0);
    assign w_num_neg  = r_num[PROD_W-1];
    assign w_num_pos  = !r_num[PROD_W-1] && (r_num != '0);

    // Forward quotient; a zero pivot gives the signed limit.
    always_comb begin
        if (!w_den_zero) begin
            w_q_fwd = w_q_s;
        end else if (w_num_pos) begin
            w_q_fwd = Q_LIMIT;
        end else if (w_num_neg) begin
            w_q_fwd = -Q_LIMIT;
        end else begin
            w_q_fwd = '0;
        end
    end
    assign w_base    = i_cmd.res_d ? r_b : r_f;
    assign w_fwd_val = tss_sat(WIDE_W'(w_base) - WIDE_W'(w_q_fwd));

    // Solution value; a zero pivot saturates by the numerator sign.
    always_comb begin
        if (!w_den_zero) begin
            w_v = tss_sat(WIDE_W'(w_q_s));
        end else if (w_num_pos) begin
            w_v = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_num_neg) begin
            w_v = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_v = '0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_a    <= i_row.coef_sub;
            r_b    <= i_row.coef_diag;
            r_c    <= i_row.coef_super;
            r_f    <= i_row.rhs;
            r_last <= i_row.last_row;
            if (r_count == '0) begin
                r_d <= i_row.coef_diag;
                r_r <= i_row.rhs;
            end
        end
        if (i_cmd.res_d) begin
            r_d <= w_fwd_val;
        end
        if (i_cmd.res_r) begin
            r_r <= w_fwd_val;
        end
        if (i_cmd.store) begin
            r_pd  <= r_d;
            r_pr  <= r_r;
            r_pc  <= r_c;
            r_top <= r_count;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.num_fwd) begin
            r_num <= r_prod;
            r_den <= r_pd;
        end
        if (i_cmd.num_back) begin
            r_num <= w_back_num;
            r_den <= w_rd_d;
        end
        if (i_cmd.emit) begin
            r_o_row  <= ROW_W'(r_k);
            r_o_sol  <= w_v;
            r_o_sing <= r_sing;
            r_o_last <= (r_k == '0);
        end
    end

    // Control registers: row count, solve index, flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_k       <= '0;
            r_sing    <= 1'b0;
            r_vnext   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                r_count <= r_count + IW'(1);
                r_k     <= r_count;
                if (r_d == '0) begin
                    r_sing <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_vnext <= w_v;
                if (r_k == '0) begin
                    r_count <= '0;
                    r_sing  <= 1'b0;
                    r_vnext <= '0;
                end else begin
                    r_k <= r_k - IW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (o_sol.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.idx_zero   = (r_count == '0);
    assign o_sts.start_back = r_last || (r_count == IW'(MAX_ROWS - 1));
    assign o_sts.div_done   = w_div_done;
    assign o_sts.out_busy   = r_o_valid && !o_sol.ready;
    assign o_sts.k_zero     = (r_k == '0);

    assign o_sol.valid       = r_o_valid;
    assign o_sol.row_index   = r_o_row;
    assign o_sol.solution    = r_o_sol;
    assign o_sol.singular    = r_o_sing;
    assign o_sol.last_result = r_o_last;
endmodule

### rtl/tridiagonal_system_solver_unit.sv
// Tridiagonal system solver, Thomas algorithm, signed fixed point.
// The row channel i_row takes one row (sub, diagonal, super, right-hand
// side, last flag) per request. Forward elimination runs on each row after
// the first as it arrives: two 64-step divisions through one shared
// restoring divider; each row is stored before the next one is accepted.
// The row flagged last, or the row at index MAX_ROWS-1, starts back
// substitution. Solutions leave on o_sol from the top row down to row
// zero, each after its own division; last_result marks row zero and
// singular reports a zero pivot anywhere in the system.
// The first solution follows one division after the last row is stored.
// The output register holds a result while the receiver stalls; the
// solver waits before producing the next value. After the final result
// is registered the block takes new rows even if that result still waits.
// Reset clears the row count, the singular flag and the output valid;
// the row store itself needs no clearing.
module tridiagonal_system_solver_unit #(
    parameter int MAX_ROWS  = tss_pkg::TSS_MAX_ROWS,
    parameter int FRAC_BITS = tss_pkg::TSS_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tss_in_if.sink    i_row,
    tss_out_if.source o_sol
);
    import tss_pkg::*;

    t_tss_cmd w_cmd;
    t_tss_sts w_sts;
    logic     w_in_ready;

    tss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_row.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    tss_dp #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_row   (i_row),
        .o_sol   (o_sol)
    );

    assign i_row.ready = w_in_ready;
endmodule

### rtl/tss_chk.sv
module tss_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [tss_pkg::ROW_W-1:0]         i_row_index,
    input logic signed [tss_pkg::DATA_W-1:0] i_solution,
    input logic                              i_last_result
);
    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_solution)
        && $stable(i_row_index))
        else $error("stalled result changed");

    // The final result is always for row zero.
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_result |-> i_row_index == '0)
        else $error("last result not row zero");

    // No rows are taken while a solve is still emitting.
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_result |-> !i_in_ready)
        else $error("row accepted during solve");

    // A waiting row request stays offered until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid)
        else $error("row request withdrawn");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind tridiagonal_system_solver_unit tss_chk u_tss_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_row.valid),
    .i_in_ready    (i_row.ready),
    .i_out_valid   (o_sol.valid),
    .i_out_ready   (o_sol.ready),
    .i_row_index   (o_sol.row_index),
    .i_solution    (o_sol.solution),
    .i_last_result (o_sol.last_result)
);

### test/tridiagonal_system_solver_unit_test.sv
`timescale 1ns / 1ps

module tridiagonal_system_solver_unit_test;
    import tss_pkg::*;

    localparam int  ROWS_CAP  = TSS_MAX_ROWS;
    localparam int  FRAC      = TSS_FRAC_BITS;
    localparam int  HOLD_LEN  = 3000;
    localparam int  TAIL_WAIT = 300;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam longint FWD_LIMIT = 64'sh4000_0000_0000_0000;

    // Idle profiles for the two sides of the block.
    typedef enum int {
        PACE_NONE,
        PACE_TX_IDLE,
        PACE_RX_STALL,
        PACE_BOTH
    } t_pace;

    typedef struct {
        logic signed [DATA_W-1:0] coef_sub;
        logic signed [DATA_W-1:0] coef_diag;
        logic signed [DATA_W-1:0] coef_super;
        logic signed [DATA_W-1:0] rhs;
        bit                       last_row;
        bit                       hold_rx;
        bit                       drain;
        t_pace                    pace;
    } t_row_req;

    typedef struct {
        logic [ROW_W-1:0]         row_index;
        logic signed [DATA_W-1:0] solution;
        logic                     singular;
        logic                     last_result;
    } t_solution;

    logic i_clk;
    logic i_rst_n;

    tss_in_if  row_if ();
    tss_out_if sol_if ();

    tridiagonal_system_solver_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_if),
        .o_sol   (sol_if)
    );

    t_row_req  pending_rows[$];
    t_solution expected_solutions[$];
    int        mismatch_count = 0;
    int        tx_idle_pct    = 0;
    int        rx_stall_pct   = 0;
    int        hold_cnt       = 0;
    logic      hold_go        = 1'b0;

    // Predictor state: eliminated rows of the current system.
    longint    pivot_mem[ROWS_CAP];
    longint    rhs_mem[ROWS_CAP];
    longint    super_mem[ROWS_CAP];
    int        rows_held     = 0;
    bit        pivot_zero    = 1'b0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip32(input longint v);
        if (v > SAT_HI) begin
            return SAT_HI;
        end else if (v < SAT_LO) begin
            return SAT_LO;
        end
        return v;
    endfunction

    // Elimination quotient; a zero pivot gives a huge value by numerator sign.
    function automatic longint elim_quot(input longint num, input longint den);
        if (den == 0) begin
            return (num > 0) ? FWD_LIMIT : ((num < 0) ? -FWD_LIMIT : 0);
        end
        return num / den;
    endfunction

    // Back-substitution quotient, saturated to 32 bits.
    function automatic longint back_quot(input longint num, input longint den);
        if (den == 0) begin
            return (num > 0) ? SAT_HI : ((num < 0) ? SAT_LO : 0);
        end
        return clip32(num / den);
    endfunction

    // Eliminate one accepted row and, on the solving row, queue the solutions.
    task automatic eliminate_row(input longint a, input longint b, input longint c,
                                 input longint f, input bit last);
        int        idx;
        longint    d;
        longint    r;
        longint    num;
        longint    v;
        longint    v_above;
        t_solution sol;
        idx = (rows_held >= ROWS_CAP) ? ROWS_CAP - 1 : rows_held;
        if (idx == 0) begin
            d = b;
            r = f;
        end else begin
            d = clip32(b - elim_quot(super_mem[idx-1] * a, pivot_mem[idx-1]));
            r = clip32(f - elim_quot(rhs_mem[idx-1] * a, pivot_mem[idx-1]));
        end
        if (d == 0) begin
            pivot_zero = 1'b1;
        end
        pivot_mem[idx] = d;
        rhs_mem[idx]   = r;
        super_mem[idx] = c;
        rows_held      = idx + 1;
        if (!last && idx != ROWS_CAP - 1) begin
            return;
        end
        v_above = 0;
        for (int k = idx; k >= 0; k--) begin
            num = rhs_mem[k] * (64'sd1 <<< FRAC);
            if (k != idx) begin
                num = num - super_mem[k] * v_above;
            end
            v = back_quot(num, pivot_mem[k]);
            v_above = v;
            sol.row_index   = k[ROW_W-1:0];
            sol.solution    = v[DATA_W-1:0];
            sol.singular    = pivot_zero;
            sol.last_result = (k == 0);
            expected_solutions.push_back(sol);
        end
        rows_held  = 0;
        pivot_zero = 1'b0;
    endtask

    task automatic report(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Row driver: one request per accepted handshake, paced by the idle profile.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_if.valid <= 1'b0;
            hold_go      <= 1'b0;
        end else if (!row_if.valid || row_if.ready) begin
            if (pending_rows.size() > 0 &&
                    !(pending_rows[0].drain &&
                      (row_if.valid || expected_solutions.size() > 0)) &&
                    ($urandom_range(0, 99) >= tx_idle_pct || pending_rows[0].drain)) begin
                row_if.coef_sub   <= pending_rows[0].coef_sub;
                row_if.coef_diag  <= pending_rows[0].coef_diag;
                row_if.coef_super <= pending_rows[0].coef_super;
                row_if.rhs        <= pending_rows[0].rhs;
                row_if.last_row   <= pending_rows[0].last_row;
                hold_go           <= pending_rows[0].hold_rx;
                case (pending_rows[0].pace)
                    PACE_NONE:     begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
                    PACE_TX_IDLE:  begin tx_idle_pct <= 60; rx_stall_pct <= 0;  end
                    PACE_RX_STALL: begin tx_idle_pct <= 0;  rx_stall_pct <= 60; end
                    default:       begin tx_idle_pct <= 25; rx_stall_pct <= 25; end
                endcase
                row_if.valid <= 1'b1;
                void'(pending_rows.pop_front());
            end else begin
                row_if.valid <= 1'b0;
                hold_go      <= 1'b0;
            end
        end else begin
            hold_go <= 1'b0;
        end
    end

    // Long receiver hold-off, counted in its own process.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_cnt <= HOLD_LEN;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Receiver ready.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_go || hold_cnt > 0) begin
            sol_if.ready <= 1'b0;
        end else begin
            sol_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Monitor: predict on each accepted row, check each accepted solution.
    always @(posedge i_clk) begin
        t_solution want;
        if (i_rst_n && row_if.valid && row_if.ready) begin
            eliminate_row(longint'(row_if.coef_sub), longint'(row_if.coef_diag),
                          longint'(row_if.coef_super), longint'(row_if.rhs),
                          row_if.last_row);
        end
        if (i_rst_n && sol_if.valid && sol_if.ready) begin
            if (expected_solutions.size() == 0) begin
                report($sformatf("unexpected solution for row %0d", sol_if.row_index));
            end else begin
                want = expected_solutions.pop_front();
                if (sol_if.row_index !== want.row_index)
                    report($sformatf("row_index %0d, want %0d",
                                     sol_if.row_index, want.row_index));
                if (sol_if.solution !== want.solution)
                    report($sformatf("row %0d solution %0d, want %0d",
                                     want.row_index, sol_if.solution, want.solution));
                if (sol_if.singular !== want.singular)
                    report($sformatf("row %0d singular %b, want %b",
                                     want.row_index, sol_if.singular, want.singular));
                if (sol_if.last_result !== want.last_result)
                    report($sformatf("row %0d last_result %b, want %b",
                                     want.row_index, sol_if.last_result,
                                     want.last_result));
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value(input bit tame);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            return '0;
        end else if (!tame || sel == 1) begin
            return $urandom;
        end
        return DATA_W'($signed($urandom_range(0, 16 << FRAC)) - (8 <<< FRAC));
    endfunction

    task automatic add_row(input longint a, input longint b, input longint c,
                           input longint f, input bit last, input t_pace pace);
        t_row_req req;
        req.coef_sub   = a[DATA_W-1:0];
        req.coef_diag  = b[DATA_W-1:0];
        req.coef_super = c[DATA_W-1:0];
        req.rhs        = f[DATA_W-1:0];
        req.last_row   = last;
        req.hold_rx    = 1'b0;
        req.drain      = 1'b0;
        req.pace       = pace;
        pending_rows.push_back(req);
    endtask

    // Stimulus, end of run.
    initial begin
        longint one;
        int     sys_rows;
        int     sys_num;
        bit     tame;
        longint b;
        i_rst_n           = 1'b0;
        one = 64'sd1 <<< FRAC;

        // Single-row systems, including zero pivots with each numerator sign.
        add_row(SAT_HI, one, SAT_LO, 3 * one, 1, PACE_NONE);
        add_row(0, 0, 0, 5 * one, 1, PACE_NONE);
        add_row(0, 0, 0, -5 * one, 1, PACE_NONE);
        add_row(0, 0, 0, 0, 1, PACE_NONE);
        // Field extremes.
        add_row(SAT_HI, SAT_LO, SAT_HI, SAT_LO, 0, PACE_NONE);
        add_row(SAT_LO, SAT_HI, SAT_LO, SAT_HI, 1, PACE_NONE);
        add_row(-1, SAT_HI, -1, -1, 0, PACE_NONE);
        add_row(SAT_HI, -1, 0, SAT_HI, 1, PACE_NONE);
        // A pivot that becomes zero in elimination of the second row.
        add_row(0, one, one, 2 * one, 0, PACE_NONE);
        add_row(one, one, one, one, 0, PACE_NONE);
        add_row(one, 4 * one, 0, one, 1, PACE_NONE);
        // A well-conditioned system with the usual second-difference stencil.
        for (int i = 0; i < 6; i++)
            add_row(-one, 2 * one, -one, one / 8 * (i + 1), i == 5, PACE_NONE);

        // Random systems; mostly diagonally dominant with random content.
        sys_num = 0;
        while (pending_rows.size() < 190) begin
            sys_rows = ($urandom_range(0, 24) == 0 || sys_num == 3 || sys_num == 9)
                       ? ROWS_CAP : $urandom_range(1, 8);
            if (sys_num == 5) sys_rows = 8;
            tame = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < sys_rows; i++) begin
                b = pick_value(tame);
                if (tame && b >= 0) b = b + 9 * one;
                else if (tame) b = b - 9 * one;
                // A full store solves by itself, so the last flag is left random there.
                add_row(pick_value(tame), b, pick_value(tame), pick_value(tame),
                        (i == sys_rows - 1) ? (sys_rows != ROWS_CAP || $urandom_range(0, 1))
                                            : ($urandom_range(0, 29) == 0 && !tame),
                        t_pace'(sys_num % 4));
                if (i == 0 && (sys_num == 0 || sys_num == 10))
                    pending_rows[$].drain = 1'b1;
            end
            if (sys_num == 5)
                pending_rows[$-5].hold_rx = 1'b1;
            sys_num++;
        end
        // Mid-system last flags may leave trailing rows unsolved; close with a solve.
        add_row(0, one, 0, one, 1, PACE_NONE);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_rows.size() == 0);
        @(posedge i_clk);
        while (row_if.valid) @(posedge i_clk);
        while (expected_solutions.size() > 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
